>>> rtl/core/i2cmbe_pkg.sv
// Shared types and constants for the I2C master bit engine.
// No dependencies; every other file in rtl/core refers to this package.
package i2cmbe_pkg;

  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = 8;

  localparam logic [CfgIndexW-1:0] CFG_ADDRESS_HIGH   = 2'd0;
  localparam logic [CfgIndexW-1:0] CFG_ADDRESS_LOW    = 2'd1;
  localparam logic [CfgIndexW-1:0] CFG_TEN_BIT_MODE   = 2'd2;
  localparam logic [CfgIndexW-1:0] CFG_ACK_POLL_LIMIT = 2'd3;

  localparam logic [7:0] ACK_POLL_LIMIT_RESET = 8'd100;

  // which address byte is on the wire
  localparam logic [1:0] ADDR_STAGE_HEADER = 2'd0;
  localparam logic [1:0] ADDR_STAGE_SECOND = 2'd1;
  localparam logic [1:0] ADDR_STAGE_SEVEN  = 2'd2;

  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_BEGIN_WR = 2'd1,
    CMD_BEGIN_RD = 2'd2,
    CMD_SUPPLY   = 2'd3
  } cmd_kind_t;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_START    = 4'd1,
    PH_ADDR_TX  = 4'd2,
    PH_ADDR_ACK = 4'd3,
    PH_WAIT     = 4'd4,
    PH_DATA_TX  = 4'd5,
    PH_DATA_ACK = 4'd6,
    PH_RX       = 4'd7,
    PH_RX_ACK   = 4'd8,
    PH_STOP     = 4'd9
  } phase_t;

  typedef enum logic [1:0] {
    ACK_POLL = 2'd0,
    ACK_OK   = 2'd1,
    ACK_NACK = 2'd2
  } ack_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] length;
    logic [7:0] data_byte;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_drive_low;
    logic       sda_is_output;
    logic       need_data;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       busy_res;
    logic       done_res;
    logic [7:0] byte_count;
    logic       address_nack;
  } out_item_t;

  // decoded command as it sits between front and back
  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] length;
    logic [7:0] data_byte;
    logic       sda_in;
  } cmd_t;

  typedef struct packed {
    phase_t     phase;
    logic [2:0] sub_step;
    logic [3:0] bit_index;
    logic [7:0] shift_reg;
    logic [7:0] bytes_done;
    logic [7:0] bytes_wanted;
    logic       is_read;
    logic [7:0] poll_count;
    logic [1:0] address_stage;
    logic       nack_seen;
    logic       byte_ready;
    logic       line_scl;
    logic       line_sda_low;
    logic       line_sda_out;
  } eng_state_t;

  // bus idle: SCL high, SDA released but still an output
  localparam eng_state_t ENG_STATE_RESET = '{
    phase: PH_IDLE, sub_step: 3'd0, bit_index: 4'd0, shift_reg: 8'd0,
    bytes_done: 8'd0, bytes_wanted: 8'd0, is_read: 1'b0, poll_count: 8'd0,
    address_stage: 2'd0, nack_seen: 1'b0, byte_ready: 1'b0,
    line_scl: 1'b1, line_sda_low: 1'b0, line_sda_out: 1'b1
  };

  // queue status handed from the command queue to the engine
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_head_t;

endpackage

>>> rtl/core/i2c_master_bit_engine.sv
// I2C master bit engine: command queue, bus sequencer and result queue.
// Path: an item is registered in the command queue, and its result in the
// result queue, before the result is on the result ports.
// Throughput: one item per cycle; the sequencer retires one queued item
// per cycle whenever the result queue has room.
// Reset (rst, synchronous): queues empty, bus idle with SCL high and SDA
// released, registers back to defaults (poll limit 100).
module i2c_master_bit_engine (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  i2cmbe_pkg::in_item_t             command,
  output logic                             empty,
  input  logic                             pop,
  output i2cmbe_pkg::out_item_t            result,
  input  logic                             cfg_we,
  input  logic [i2cmbe_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [i2cmbe_pkg::CfgDataW-1:0]  cfg_data
);

  i2cmbe_pkg::cmd_head_t head;
  i2cmbe_pkg::out_item_t res_data;
  logic                  take;
  logic                  res_full;

  i2cmbe_cmd_queue u_cmd_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .command (command),
    .head    (head),
    .take    (take)
  );

  i2cmbe_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .head      (head),
    .res_full  (res_full),
    .take      (take),
    .res_data  (res_data)
  );

  i2cmbe_res_queue u_res_queue (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (take),
    .wr_data     (res_data),
    .almost_full (res_full),
    .empty       (empty),
    .pop         (pop),
    .result      (result)
  );

endmodule

>>> rtl/core/i2cmbe_cmd_queue.sv
// Front end: accepts input items, decodes the action and holds them in a
// two-entry queue for the engine. Depends on i2cmbe_pkg.
module i2cmbe_cmd_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  i2cmbe_pkg::in_item_t command,
  output i2cmbe_pkg::cmd_head_t head,
  input  logic                 take
);

  i2cmbe_pkg::cmd_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       wr_en;
  logic       rd_en;
  i2cmbe_pkg::cmd_t decoded;

  always_comb begin
    decoded.kind      = i2cmbe_pkg::cmd_kind_t'(command.action);
    decoded.length    = command.length;
    decoded.data_byte = command.data_byte;
    decoded.sda_in    = command.sda_in;
  end

  assign full       = (count == 2'd2);
  assign wr_en      = push && !full;
  assign rd_en      = take && (count != 2'd0);
  assign head.valid = (count != 2'd0);
  assign head.cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) wr_ptr <= ~wr_ptr;
      if (rd_en) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

endmodule

>>> rtl/core/i2cmbe_res_queue.sv
// Output side: two-entry result queue between the engine and the consumer,
// so the engine keeps going while a result waits. Depends on i2cmbe_pkg.
module i2cmbe_res_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  i2cmbe_pkg::out_item_t wr_data,
  output logic                  almost_full,
  output logic                  empty,
  input  logic                  pop,
  output i2cmbe_pkg::out_item_t result
);

  i2cmbe_pkg::out_item_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       rd_en;

  assign almost_full = (count == 2'd2);
  assign empty       = (count == 2'd0);
  assign rd_en       = pop && !empty;
  assign result      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) wr_ptr <= ~wr_ptr;
      if (rd_en) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

endmodule

>>> rtl/core/i2cmbe_engine.sv
// Back end: bus sequencer that steps SCL/SDA one command per cycle while the
// result queue has room, and holds the configuration registers. Depends on i2cmbe_pkg.
module i2cmbe_engine (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [i2cmbe_pkg::CfgIndexW-1:0]       cfg_index,
  input  logic [i2cmbe_pkg::CfgDataW-1:0]        cfg_data,
  input  i2cmbe_pkg::cmd_head_t                  head,
  input  logic                                   res_full,
  output logic                                   take,
  output i2cmbe_pkg::out_item_t                  res_data
);

  logic [7:0] address_high;
  logic [7:0] address_low;
  logic       ten_bit_mode;
  logic [7:0] ack_poll_limit;

  i2cmbe_pkg::eng_state_t st;
  i2cmbe_pkg::eng_state_t st_next;
  logic       rx_valid;
  logic       done;
  logic [7:0] addr_header;
  logic [7:0] addr_seven;

  assign take        = head.valid && !res_full;
  assign addr_header = {address_high[7:1], st.is_read};
  assign addr_seven  = {address_low[7:1], st.is_read};

  always_ff @(posedge clk) begin
    if (rst) begin
      address_high   <= 8'd0;
      address_low    <= 8'd0;
      ten_bit_mode   <= 1'b0;
      ack_poll_limit <= i2cmbe_pkg::ACK_POLL_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        i2cmbe_pkg::CFG_ADDRESS_HIGH:   address_high   <= cfg_data;
        i2cmbe_pkg::CFG_ADDRESS_LOW:    address_low    <= cfg_data;
        i2cmbe_pkg::CFG_TEN_BIT_MODE:   ten_bit_mode   <= cfg_data[0];
        i2cmbe_pkg::CFG_ACK_POLL_LIMIT: ack_poll_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= i2cmbe_pkg::ENG_STATE_RESET;
    end else if (take) begin
      st <= st_next;
    end
  end

  always_comb begin
    i2cmbe_pkg::ack_t ack_r;
    ack_r    = i2cmbe_pkg::ACK_POLL;
    st_next  = st;
    rx_valid = 1'b0;
    done     = 1'b0;

    case (head.cmd.kind)
      i2cmbe_pkg::CMD_BEGIN_WR, i2cmbe_pkg::CMD_BEGIN_RD: begin
        if (st.phase == i2cmbe_pkg::PH_IDLE) begin
          st_next.is_read      = (head.cmd.kind == i2cmbe_pkg::CMD_BEGIN_RD);
          st_next.bytes_wanted = head.cmd.length;
          // a zero-length read still moves one byte
          if (st_next.is_read && head.cmd.length == 8'd0) st_next.bytes_wanted = 8'd1;
          st_next.bytes_done = 8'd0;
          st_next.nack_seen  = 1'b0;
          st_next.byte_ready = 1'b0;
          st_next.poll_count = 8'd0;
          st_next.bit_index  = 4'd0;
          st_next.phase      = i2cmbe_pkg::PH_START;
          st_next.sub_step   = 3'd0;
        end
      end
      i2cmbe_pkg::CMD_SUPPLY: begin
        if (st.phase == i2cmbe_pkg::PH_WAIT && !st.byte_ready) begin
          st_next.shift_reg  = head.cmd.data_byte;
          st_next.byte_ready = 1'b1;
        end
      end
      default: begin
        case (st.phase)
          i2cmbe_pkg::PH_START: begin
            case (st.sub_step)
              3'd0: begin
                st_next.line_scl = 1'b0; st_next.sub_step = 3'd1;
              end
              3'd1: begin
                st_next.line_sda_out = 1'b1; st_next.line_sda_low = 1'b0;
                st_next.sub_step = 3'd2;
              end
              3'd2: begin
                st_next.line_scl = 1'b1; st_next.sub_step = 3'd3;
              end
              3'd3: begin
                st_next.line_sda_low = 1'b1; st_next.sub_step = 3'd4;
              end
              default: begin
                st_next.line_scl = 1'b0;
                st_next.phase    = i2cmbe_pkg::PH_ADDR_TX;
                st_next.sub_step = 3'd0;
                if (ten_bit_mode) begin
                  st_next.address_stage = i2cmbe_pkg::ADDR_STAGE_HEADER;
                  st_next.shift_reg     = addr_header;
                end else begin
                  st_next.address_stage = i2cmbe_pkg::ADDR_STAGE_SEVEN;
                  st_next.shift_reg     = addr_seven;
                end
              end
            endcase
          end

          i2cmbe_pkg::PH_ADDR_TX, i2cmbe_pkg::PH_DATA_TX: begin
            case (st.sub_step)
              3'd0: begin
                st_next.line_scl = 1'b0; st_next.line_sda_out = 1'b1;
                st_next.bit_index = 4'd0; st_next.sub_step = 3'd1;
              end
              3'd1: begin
                // MSB first
                st_next.line_sda_low = ~st.shift_reg[~st.bit_index[2:0]];
                st_next.line_scl = 1'b1; st_next.sub_step = 3'd2;
              end
              default: begin
                st_next.line_scl  = 1'b0;
                st_next.bit_index = st.bit_index + 4'd1;
                if (st_next.bit_index >= 4'd8) begin
                  st_next.phase = (st.phase == i2cmbe_pkg::PH_ADDR_TX) ?
                                  i2cmbe_pkg::PH_ADDR_ACK : i2cmbe_pkg::PH_DATA_ACK;
                  st_next.sub_step = 3'd0;
                end else begin
                  st_next.sub_step = 3'd1;
                end
              end
            endcase
          end

          i2cmbe_pkg::PH_ADDR_ACK, i2cmbe_pkg::PH_DATA_ACK: begin
            case (st.sub_step)
              3'd0: begin
                st_next.line_scl = 1'b0; st_next.line_sda_out = 1'b0;
                st_next.line_sda_low = 1'b0; st_next.poll_count = 8'd0;
                st_next.sub_step = 3'd1;
              end
              3'd1: begin
                st_next.line_scl = 1'b1; st_next.sub_step = 3'd2;
              end
              default: begin
                if (!head.cmd.sda_in) begin
                  st_next.line_scl = 1'b0; ack_r = i2cmbe_pkg::ACK_OK;
                end else if (st.poll_count < ack_poll_limit) begin
                  st_next.poll_count = st.poll_count + 8'd1;
                end else begin
                  st_next.line_scl = 1'b0; ack_r = i2cmbe_pkg::ACK_NACK;
                end
              end
            endcase

            if (st.phase == i2cmbe_pkg::PH_ADDR_ACK) begin
              if (ack_r != i2cmbe_pkg::ACK_POLL) begin
                if (ack_r == i2cmbe_pkg::ACK_NACK) st_next.nack_seen = 1'b1;
                st_next.sub_step = 3'd0;
                if (st.address_stage == i2cmbe_pkg::ADDR_STAGE_HEADER) begin
                  // second byte of a 10-bit address goes out even after a NACK
                  st_next.address_stage = i2cmbe_pkg::ADDR_STAGE_SECOND;
                  st_next.shift_reg     = address_low;
                  st_next.phase         = i2cmbe_pkg::PH_ADDR_TX;
                end else if (st_next.nack_seen) begin
                  st_next.phase = i2cmbe_pkg::PH_STOP;
                end else if (st.is_read) begin
                  st_next.phase = i2cmbe_pkg::PH_RX;
                end else if (st.bytes_done < st.bytes_wanted) begin
                  st_next.phase = i2cmbe_pkg::PH_WAIT; st_next.byte_ready = 1'b0;
                end else begin
                  st_next.phase = i2cmbe_pkg::PH_STOP;
                end
              end
            end else begin
              if (ack_r == i2cmbe_pkg::ACK_OK) begin
                st_next.bytes_done = st.bytes_done + 8'd1;
                st_next.sub_step   = 3'd0;
                if (st_next.bytes_done < st.bytes_wanted) begin
                  st_next.phase = i2cmbe_pkg::PH_WAIT; st_next.byte_ready = 1'b0;
                end else begin
                  st_next.phase = i2cmbe_pkg::PH_STOP;
                end
              end else if (ack_r == i2cmbe_pkg::ACK_NACK) begin
                st_next.phase = i2cmbe_pkg::PH_STOP; st_next.sub_step = 3'd0;
              end
            end
          end

          i2cmbe_pkg::PH_WAIT: begin
            if (st.byte_ready) begin
              // first data bit slot starts in the same tick
              st_next.byte_ready   = 1'b0;
              st_next.phase        = i2cmbe_pkg::PH_DATA_TX;
              st_next.line_scl     = 1'b0;
              st_next.line_sda_out = 1'b1;
              st_next.bit_index    = 4'd0;
              st_next.sub_step     = 3'd1;
            end
          end

          i2cmbe_pkg::PH_RX: begin
            case (st.sub_step)
              3'd0: begin
                st_next.line_scl = 1'b0; st_next.line_sda_out = 1'b0;
                st_next.line_sda_low = 1'b0; st_next.bit_index = 4'd0;
                st_next.shift_reg = 8'd0; st_next.sub_step = 3'd1;
              end
              3'd1: begin
                st_next.line_scl = 1'b1; st_next.sub_step = 3'd2;
              end
              default: begin
                st_next.shift_reg = {st.shift_reg[6:0], head.cmd.sda_in};
                st_next.line_scl  = 1'b0;
                st_next.bit_index = st.bit_index + 4'd1;
                if (st_next.bit_index >= 4'd8) begin
                  rx_valid           = 1'b1;
                  st_next.bytes_done = st.bytes_done + 8'd1;
                  st_next.phase      = i2cmbe_pkg::PH_RX_ACK;
                  st_next.sub_step   = 3'd0;
                end else begin
                  st_next.sub_step = 3'd1;
                end
              end
            endcase
          end

          i2cmbe_pkg::PH_RX_ACK: begin
            case (st.sub_step)
              3'd0: begin
                st_next.line_scl = 1'b0; st_next.sub_step = 3'd1;
              end
              3'd1: begin
                // ACK while more bytes follow, NACK on the last
                st_next.line_sda_out = 1'b1;
                st_next.line_sda_low = (st.bytes_done < st.bytes_wanted);
                st_next.sub_step = 3'd2;
              end
              3'd2: begin
                st_next.line_scl = 1'b1; st_next.sub_step = 3'd3;
              end
              default: begin
                st_next.line_scl = 1'b0;
                st_next.sub_step = 3'd0;
                st_next.phase = (st.bytes_done < st.bytes_wanted) ?
                                i2cmbe_pkg::PH_RX : i2cmbe_pkg::PH_STOP;
              end
            endcase
          end

          i2cmbe_pkg::PH_STOP: begin
            case (st.sub_step)
              3'd0: begin
                st_next.line_scl = 1'b0; st_next.sub_step = 3'd1;
              end
              3'd1: begin
                st_next.line_sda_out = 1'b1; st_next.line_sda_low = 1'b1;
                st_next.sub_step = 3'd2;
              end
              3'd2: begin
                st_next.line_scl = 1'b1; st_next.sub_step = 3'd3;
              end
              default: begin
                st_next.line_sda_low = 1'b0;
                done             = 1'b1;
                st_next.phase    = i2cmbe_pkg::PH_IDLE;
                st_next.sub_step = 3'd0;
              end
            endcase
          end

          default: begin
            st_next.phase    = i2cmbe_pkg::PH_IDLE;
            st_next.sub_step = 3'd0;
          end
        endcase
      end
    endcase
  end

  always_comb begin
    res_data.scl_level     = st_next.line_scl;
    res_data.sda_drive_low = st_next.line_sda_low;
    res_data.sda_is_output = st_next.line_sda_out;
    res_data.need_data     = (st_next.phase == i2cmbe_pkg::PH_WAIT) && !st_next.byte_ready;
    res_data.rx_byte       = rx_valid ? st_next.shift_reg : 8'd0;
    res_data.rx_valid      = rx_valid;
    res_data.busy_res      = (st_next.phase != i2cmbe_pkg::PH_IDLE);
    res_data.done_res      = done;
    res_data.byte_count    = done ? st_next.bytes_done : 8'd0;
    res_data.address_nack  = done && st_next.nack_seen;
  end

endmodule

>>> test/i2c_master_bit_engine_tb.sv
// Self-checking testbench for i2c_master_bit_engine: an in-bench bus model predicts every
// result while a simple target answers acknowledges and read bits. Depends on i2cmbe_pkg.
module i2c_master_bit_engine_tb;
  import i2cmbe_pkg::*;

  logic clk = 1'b0;
  logic rst;
  logic push, full, empty, pop;
  in_item_t command;
  out_item_t result;
  logic cfg_we;
  logic [CfgIndexW-1:0] cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  i2c_master_bit_engine DUT (
    .clk(clk), .rst(rst), .push(push), .full(full), .command(command),
    .empty(empty), .pop(pop), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // bus model: registers
  logic [7:0] addr_hi_reg = 8'h00;
  logic [7:0] addr_lo_reg = 8'h00;
  logic ten_bit_reg = 1'b0;
  logic [7:0] poll_limit_reg = ACK_POLL_LIMIT_RESET;
  // bus model: sequencer and line state
  phase_t bus_phase = PH_IDLE;
  logic [2:0] half_step = '0;
  logic [3:0] bit_pos = '0;
  logic [7:0] shreg = '0, moved = '0, wanted = '0, poll_ticks = '0;
  logic [1:0] addr_byte = '0;
  logic reading = 1'b0, got_nack = 1'b0, tx_loaded = 1'b0;
  logic scl_q = 1'b1, sda_low_q = 1'b0, sda_oe_q = 1'b1;

  out_item_t bus_results_q[$];
  int errors = 0, sent = 0, checked = 0;
  int finished = 0, addr_nacks = 0, bytes_read = 0;
  bit steady = 1'b0;

  function automatic void enter_phase(phase_t ph);
    bus_phase = ph;
    half_step = '0;
  endfunction

  function automatic void load_addr(logic [1:0] stage);
    addr_byte = stage;
    case (stage)
      ADDR_STAGE_HEADER: shreg = {addr_hi_reg[7:1], reading};
      ADDR_STAGE_SECOND: shreg = addr_lo_reg;
      default:           shreg = {addr_lo_reg[7:1], reading};
    endcase
    enter_phase(PH_ADDR_TX);
  endfunction

  function automatic void shift_out_step();
    if (half_step == 3'd0) begin
      scl_q = 1'b0; sda_oe_q = 1'b1; bit_pos = '0; half_step = 3'd1;
    end else if (half_step == 3'd1) begin
      sda_low_q = ~shreg[3'd7 - bit_pos[2:0]];
      scl_q = 1'b1; half_step = 3'd2;
    end else begin
      scl_q = 1'b0;
      bit_pos++;
      if (bit_pos >= 4'd8) enter_phase(bus_phase == PH_ADDR_TX ? PH_ADDR_ACK : PH_DATA_ACK);
      else half_step = 3'd1;
    end
  endfunction

  function automatic ack_t ack_step(logic sda);
    if (half_step == 3'd0) begin
      scl_q = 1'b0; sda_oe_q = 1'b0; sda_low_q = 1'b0; poll_ticks = '0; half_step = 3'd1;
      return ACK_POLL;
    end
    if (half_step == 3'd1) begin
      scl_q = 1'b1; half_step = 3'd2;
      return ACK_POLL;
    end
    if (!sda) begin
      scl_q = 1'b0;
      return ACK_OK;
    end
    if (poll_ticks < poll_limit_reg) begin
      poll_ticks++;
      return ACK_POLL;
    end
    scl_q = 1'b0;
    return ACK_NACK;
  endfunction

  function automatic void next_write_byte();
    if (moved < wanted) begin
      enter_phase(PH_WAIT);
      tx_loaded = 1'b0;
    end else begin
      enter_phase(PH_STOP);
    end
  endfunction

  function automatic out_item_t predict_bus(in_item_t c);
    out_item_t r;
    logic rxv, fin;
    ack_t a;
    rxv = 1'b0;
    fin = 1'b0;
    case (cmd_kind_t'(c.action))
      CMD_BEGIN_WR, CMD_BEGIN_RD: begin
        if (bus_phase == PH_IDLE) begin
          reading = (c.action == CMD_BEGIN_RD);
          wanted = c.length;
          if (reading && wanted == 8'd0) wanted = 8'd1;
          moved = '0; got_nack = 1'b0; tx_loaded = 1'b0; poll_ticks = '0; bit_pos = '0;
          enter_phase(PH_START);
        end
      end
      CMD_SUPPLY: begin
        if (bus_phase == PH_WAIT && !tx_loaded) begin
          shreg = c.data_byte;
          tx_loaded = 1'b1;
        end
      end
      default: begin
        case (bus_phase)
          PH_START: begin
            case (half_step)
              3'd0: begin scl_q = 1'b0; half_step = 3'd1; end
              3'd1: begin sda_oe_q = 1'b1; sda_low_q = 1'b0; half_step = 3'd2; end
              3'd2: begin scl_q = 1'b1; half_step = 3'd3; end
              3'd3: begin sda_low_q = 1'b1; half_step = 3'd4; end
              default: begin
                scl_q = 1'b0;
                load_addr(ten_bit_reg ? ADDR_STAGE_HEADER : ADDR_STAGE_SEVEN);
              end
            endcase
          end
          PH_ADDR_TX, PH_DATA_TX: shift_out_step();
          PH_ADDR_ACK: begin
            a = ack_step(c.sda_in);
            if (a != ACK_POLL) begin
              if (a == ACK_NACK) got_nack = 1'b1;
              // in 10-bit mode the second byte goes out even after a NACK
              if (addr_byte == ADDR_STAGE_HEADER) load_addr(ADDR_STAGE_SECOND);
              else if (got_nack) enter_phase(PH_STOP);
              else if (reading) enter_phase(PH_RX);
              else next_write_byte();
            end
          end
          PH_WAIT: begin
            if (tx_loaded) begin
              tx_loaded = 1'b0;
              enter_phase(PH_DATA_TX);
              shift_out_step();
            end
          end
          PH_DATA_ACK: begin
            a = ack_step(c.sda_in);
            if (a == ACK_OK) begin
              moved++;
              next_write_byte();
            end else if (a == ACK_NACK) begin
              enter_phase(PH_STOP);
            end
          end
          PH_RX: begin
            if (half_step == 3'd0) begin
              scl_q = 1'b0; sda_oe_q = 1'b0; sda_low_q = 1'b0;
              bit_pos = '0; shreg = '0; half_step = 3'd1;
            end else if (half_step == 3'd1) begin
              scl_q = 1'b1; half_step = 3'd2;
            end else begin
              shreg = {shreg[6:0], c.sda_in};
              scl_q = 1'b0;
              bit_pos++;
              if (bit_pos >= 4'd8) begin
                rxv = 1'b1;
                moved++;
                enter_phase(PH_RX_ACK);
              end else begin
                half_step = 3'd1;
              end
            end
          end
          PH_RX_ACK: begin
            case (half_step)
              3'd0: begin scl_q = 1'b0; half_step = 3'd1; end
              3'd1: begin sda_oe_q = 1'b1; sda_low_q = (moved < wanted); half_step = 3'd2; end
              3'd2: begin scl_q = 1'b1; half_step = 3'd3; end
              default: begin
                scl_q = 1'b0;
                enter_phase(moved < wanted ? PH_RX : PH_STOP);
              end
            endcase
          end
          PH_STOP: begin
            case (half_step)
              3'd0: begin scl_q = 1'b0; half_step = 3'd1; end
              3'd1: begin sda_oe_q = 1'b1; sda_low_q = 1'b1; half_step = 3'd2; end
              3'd2: begin scl_q = 1'b1; half_step = 3'd3; end
              default: begin
                sda_low_q = 1'b0;
                fin = 1'b1;
                enter_phase(PH_IDLE);
              end
            endcase
          end
          default: enter_phase(PH_IDLE);
        endcase
      end
    endcase
    r.scl_level     = scl_q;
    r.sda_drive_low = sda_low_q;
    r.sda_is_output = sda_oe_q;
    r.need_data     = (bus_phase == PH_WAIT) && !tx_loaded;
    r.rx_byte       = rxv ? shreg : 8'h00;
    r.rx_valid      = rxv;
    r.busy_res      = (bus_phase != PH_IDLE);
    r.done_res      = fin;
    r.byte_count    = fin ? moved : 8'h00;
    r.address_nack  = fin ? got_nack : 1'b0;
    return r;
  endfunction

  function automatic in_item_t mk_item(cmd_kind_t act, logic [7:0] len, logic [7:0] data,
                                       logic sda);
    in_item_t c;
    c.action    = act;
    c.length    = len;
    c.data_byte = data;
    c.sda_in    = sda;
    return c;
  endfunction

  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 3) == 0) b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return b;
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  function automatic void check_bit(string name, logic want, logic got);
    if (want !== got) begin
      $error("%s: expected %0b, got %0b", name, want, got);
      errors++;
    end
  endfunction

  // one transfer; called just after a rising edge, leaves push high for back-to-back items
  task automatic send_command(in_item_t c);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    command <= c;
    @(posedge clk);
    while (full) @(posedge clk);
    bus_results_q.push_back(predict_bus(c));
    sent++;
  endtask

  // hold off until every expected result has been popped and the engine has settled
  task automatic drain_bus();
    push <= 1'b0;
    while (bus_results_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(logic [7:0] hi, logic [7:0] lo, logic ten, logic [7:0] lim);
    cfg_we <= 1'b1;
    cfg_index <= CFG_ADDRESS_HIGH;   cfg_data <= hi;  @(posedge clk);
    cfg_index <= CFG_ADDRESS_LOW;    cfg_data <= lo;  @(posedge clk);
    cfg_index <= CFG_TEN_BIT_MODE;   cfg_data <= {7'd0, ten}; @(posedge clk);
    cfg_index <= CFG_ACK_POLL_LIMIT; cfg_data <= lim; @(posedge clk);
    cfg_we <= 1'b0;
    addr_hi_reg = hi;
    addr_lo_reg = lo;
    ten_bit_reg = ten;
    poll_limit_reg = lim;
  endtask

  // plays the target: acks with the given odds, forced NACKs, random read bits, noise
  task automatic run_transfer(cmd_kind_t kind, logic [7:0] len, bit addr_nak, int data_acks,
                              int ack_pct, int noise_pct);
    logic sda;
    send_command(mk_item(kind, len, pick_byte(), rand_bit()));
    while (bus_phase != PH_IDLE) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        // mostly ignored: begin while busy, byte nobody asked for
        send_command(mk_item(cmd_kind_t'(2'($urandom_range(0, 3))), pick_byte(), pick_byte(),
                             rand_bit()));
      end else begin
        if (bus_phase == PH_WAIT && !tx_loaded && $urandom_range(0, 3) != 0) begin
          send_command(mk_item(CMD_SUPPLY, pick_byte(), pick_byte(), rand_bit()));
        end else begin
          sda = rand_bit();
          if (half_step == 3'd2 && (bus_phase == PH_ADDR_ACK || bus_phase == PH_DATA_ACK)) begin
            if ((bus_phase == PH_ADDR_ACK && addr_nak) ||
                (bus_phase == PH_DATA_ACK && moved >= data_acks))
              sda = 1'b1;
            else
              sda = ($urandom_range(0, 99) >= ack_pct);
          end
          send_command(mk_item(CMD_TICK, pick_byte(), pick_byte(), sda));
        end
      end
    end
  endtask

  task automatic test_idle_commands();
    send_command(mk_item(CMD_TICK, 8'h00, 8'h00, 1'b0));
    send_command(mk_item(CMD_TICK, 8'hFF, 8'hFF, 1'b1));
    send_command(mk_item(CMD_SUPPLY, 8'h00, 8'h00, 1'b0));
    send_command(mk_item(CMD_SUPPLY, 8'hFF, 8'hFF, 1'b1));
    // reset register values still in force
    run_transfer(CMD_BEGIN_WR, 8'd1, 1'b0, 256, 100, 0);
  endtask

  task automatic test_seven_bit();
    drain_bus();
    set_config(8'hFF, 8'hFF, 1'b0, 8'd100);
    run_transfer(CMD_BEGIN_WR, 8'd2, 1'b0, 256, 100, 0);
    run_transfer(CMD_BEGIN_RD, 8'd3, 1'b0, 256, 100, 0);
    run_transfer(CMD_BEGIN_RD, 8'd0, 1'b0, 256, 100, 0);   // raised to one byte
    run_transfer(CMD_BEGIN_WR, 8'd0, 1'b0, 256, 100, 0);   // address then stop
    drain_bus();
    set_config(8'h00, 8'h00, 1'b0, 8'd3);
    run_transfer(CMD_BEGIN_RD, 8'd2, 1'b0, 256, 50, 30);
    run_transfer(CMD_BEGIN_WR, 8'd3, 1'b0, 256, 50, 30);
  endtask

  task automatic test_ten_bit();
    drain_bus();
    set_config(8'hF6, 8'hA5, 1'b1, 8'd10);
    run_transfer(CMD_BEGIN_WR, 8'd2, 1'b0, 256, 80, 0);
    run_transfer(CMD_BEGIN_RD, 8'd2, 1'b0, 256, 80, 0);
    // header NACKed: second byte still goes out, no data phase
    run_transfer(CMD_BEGIN_WR, 8'hFF, 1'b1, 256, 0, 0);
    run_transfer(CMD_BEGIN_RD, 8'hFF, 1'b1, 256, 0, 0);
  endtask

  task automatic test_ack_polling();
    drain_bus();
    set_config(8'h01, 8'hFE, 1'b0, 8'd0);     // single sample per acknowledge
    run_transfer(CMD_BEGIN_WR, 8'd3, 1'b0, 256, 50, 0);
    run_transfer(CMD_BEGIN_RD, 8'd1, 1'b0, 256, 50, 0);
    drain_bus();
    set_config(8'h7F, 8'h80, 1'b1, 8'd255);
    // long write cut short by a data NACK after two bytes
    run_transfer(CMD_BEGIN_WR, 8'd255, 1'b0, 2, 30, 0);
  endtask

  task automatic test_random_traffic();
    int sel, acks, pct;
    cmd_kind_t kind;
    logic [7:0] len, lim;
    bit nak;
    // batches until roughly 1800 items have gone in overall; the last batch runs past it
    do begin
      drain_bus();
      case ($urandom_range(0, 5))
        0: lim = 8'd0;
        1: lim = 8'd1;
        2: lim = 8'd255;
        3: lim = ACK_POLL_LIMIT_RESET;
        default: lim = 8'($urandom_range(1, 12));
      endcase
      set_config(pick_byte(), pick_byte(), rand_bit(), lim);
      steady = ($urandom_range(0, 4) == 0);
      repeat ($urandom_range(3, 6)) begin
        kind = $urandom_range(0, 1) ? CMD_BEGIN_RD : CMD_BEGIN_WR;
        sel = $urandom_range(0, 9);
        nak = ($urandom_range(0, 9) == 0);
        acks = 256;
        if (sel < 6) begin
          len = 8'($urandom_range(0, 3));
        end else if (sel < 9) begin
          len = 8'($urandom_range(4, 8));
        end else begin
          // wide lengths kept short on the wire by an early NACK
          len = 8'($urandom_range(9, 255));
          if (kind == CMD_BEGIN_RD) nak = 1'b1;
          else acks = $urandom_range(0, 2);
        end
        if (acks == 256 && $urandom_range(0, 4) == 0) acks = $urandom_range(0, len);
        case ($urandom_range(0, 2))
          0: pct = 95;
          1: pct = 60;
          default: pct = 20;
        endcase
        run_transfer(kind, len, nak, acks, pct, ($urandom_range(0, 3) == 0) ? 10 : 0);
      end
    end while (sent < 1800);
    steady = 1'b0;
  endtask

  initial begin : result_checker
    out_item_t want, got;
    int stall;
    pop <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      got = result;
      if (bus_results_q.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
      end else begin
        want = bus_results_q.pop_front();
        checked++;
        check_bit("scl_level", want.scl_level, got.scl_level);
        check_bit("sda_drive_low", want.sda_drive_low, got.sda_drive_low);
        check_bit("sda_is_output", want.sda_is_output, got.sda_is_output);
        check_bit("need_data", want.need_data, got.need_data);
        check_field("rx_byte", want.rx_byte, got.rx_byte);
        check_bit("rx_valid", want.rx_valid, got.rx_valid);
        check_bit("busy_res", want.busy_res, got.busy_res);
        check_bit("done_res", want.done_res, got.done_res);
        check_field("byte_count", want.byte_count, got.byte_count);
        check_bit("address_nack", want.address_nack, got.address_nack);
        if (want.done_res) finished++;
        if (want.done_res && want.address_nack) addr_nacks++;
        if (want.rx_valid) bytes_read++;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    push <= 1'b0;
    command <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_idle_commands();
    test_seven_bit();
    test_ten_bit();
    test_ack_polling();
    test_random_traffic();
    drain_bus();
    $display("%0d bus transactions done, %0d address NACKs, %0d bytes read",
             finished, addr_nacks, bytes_read);
    $display("%0d commands accepted, %0d results compared", sent, checked);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
